// File: design/stp_pkg.sv
// ----------------------------------------------------------------------------
// stp_pkg
// shared constants and the token that walks the cell chain
// ----------------------------------------------------------------------------
package stp_pkg;

   localparam int ENTRY_COUNT = 64;

   localparam logic [1:0] MODE_BEGIN = 2'd0;
   localparam logic [1:0] MODE_END   = 2'd1;
   localparam logic [1:0] MODE_READ  = 2'd2;

   localparam logic [1:0] STATUS_OK        = 2'd0;
   localparam logic [1:0] STATUS_FULL      = 2'd1;
   localparam logic [1:0] STATUS_NOT_FOUND = 2'd2;

   localparam logic [63:0] SUM_MAX   = {64{1'b1}};
   localparam logic [31:0] CALLS_MAX = {32{1'b1}};
   localparam logic [47:0] TIME_ONES = {48{1'b1}};

   typedef struct packed {
      logic        valid;
      logic        done;
      logic [1:0]  mode;
      logic [15:0] key;
      logic [47:0] stamp;
      logic [1:0]  status;
      logic [31:0] call_count;
      logic [63:0] total_time;
      logic [47:0] low_time;
      logic [47:0] high_time;
   } token_type;

endpackage

// File: design/stp_if.sv
// ----------------------------------------------------------------------------
// stp_if
// request and response channels of the profiler table
// ----------------------------------------------------------------------------
interface stp_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  mode;
   logic [15:0] section_key;
   logic [47:0] timestamp;

   modport source (output valid, mode, section_key, timestamp, input ready);
   modport sink   (input valid, mode, section_key, timestamp, output ready);
endinterface

interface stp_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  status;
   logic [31:0] call_count;
   logic [63:0] total_time;
   logic [47:0] low_time;
   logic [47:0] high_time;

   modport source (output valid, status, call_count, total_time, low_time, high_time,
                   input ready);
   modport sink   (input valid, status, call_count, total_time, low_time, high_time,
                   output ready);
endinterface

// File: design/stp_cell.sv
// ----------------------------------------------------------------------------
// stp_cell
// one table entry; updates itself when the passing token hits it
// ----------------------------------------------------------------------------
module stp_cell (
   input  logic              clock,
   input  logic              reset,
   input  stp_pkg::token_type tok_in,
   output stp_pkg::token_type tok_out
);
   import stp_pkg::*;

   logic        used_ff, used_in;
   logic [15:0] key_ff, key_in;
   logic [47:0] start_ff, start_in;
   logic [31:0] calls_ff, calls_in;
   logic [63:0] sum_ff, sum_in;
   logic [47:0] min1_ff, min1_in, min2_ff, min2_in;
   logic [47:0] max1_ff, max1_in, max2_ff, max2_in;
   logic [1:0]  seen_ff, seen_in;
   token_type   tok_ff, tok_in_nx;

   logic        active, is_begin, is_end, hit;
   logic [47:0] elapsed;
   logic [64:0] sum_wide;

   always_comb begin
      active   = tok_in.valid && !tok_in.done;
      is_begin = (tok_in.mode == MODE_BEGIN);
      is_end   = (tok_in.mode == MODE_END);
      hit      = is_begin ? (!used_ff || key_ff == tok_in.key)
                          : (used_ff && key_ff == tok_in.key);
      elapsed  = tok_in.stamp - start_ff;
      sum_wide = {1'b0, sum_ff} + {17'd0, elapsed};

      used_in  = used_ff;
      key_in   = key_ff;
      start_in = start_ff;
      calls_in = calls_ff;
      sum_in   = sum_ff;
      min1_in  = min1_ff;
      min2_in  = min2_ff;
      max1_in  = max1_ff;
      max2_in  = max2_ff;
      seen_in  = seen_ff;

      if (active && hit && is_begin) begin
         used_in  = 1'b1;
         key_in   = tok_in.key;
         start_in = tok_in.stamp;
         if (calls_ff != CALLS_MAX) calls_in = calls_ff + 32'd1;
      end
      if (active && hit && is_end) begin
         if (elapsed < min2_ff) begin
            if (elapsed < min1_ff) begin
               min2_in = min1_ff;
               min1_in = elapsed;
            end else begin
               min2_in = elapsed;
            end
         end
         if (elapsed > max2_ff) begin
            if (elapsed > max1_ff) begin
               max2_in = max1_ff;
               max1_in = elapsed;
            end else begin
               max2_in = elapsed;
            end
         end
         sum_in = sum_wide[64] ? SUM_MAX : sum_wide[63:0];
         if (seen_ff != 2'd2) seen_in = seen_ff + 2'd1;
      end

      tok_in_nx = tok_in;
      if (active && hit) begin
         tok_in_nx.done       = 1'b1;
         tok_in_nx.status     = STATUS_OK;
         tok_in_nx.call_count = calls_in;
         tok_in_nx.total_time = sum_in;
         unique case (seen_in)
            2'd0: begin
               tok_in_nx.low_time  = '0;
               tok_in_nx.high_time = '0;
            end
            2'd1: begin
               tok_in_nx.low_time  = min1_in;
               tok_in_nx.high_time = max1_in;
            end
            default: begin
               tok_in_nx.low_time  = min2_in;
               tok_in_nx.high_time = max2_in;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      key_ff   <= key_in;
      start_ff <= start_in;
      if (reset) begin
         used_ff  <= 1'b0;
         calls_ff <= '0;
         sum_ff   <= '0;
         min1_ff  <= TIME_ONES;
         min2_ff  <= TIME_ONES;
         max1_ff  <= '0;
         max2_ff  <= '0;
         seen_ff  <= '0;
         tok_ff   <= '0;
      end else begin
         used_ff  <= used_in;
         calls_ff <= calls_in;
         sum_ff   <= sum_in;
         min1_ff  <= min1_in;
         min2_ff  <= min2_in;
         max1_ff  <= max1_in;
         max2_ff  <= max2_in;
         seen_ff  <= seen_in;
         tok_ff   <= tok_in_nx;
      end
   end

   assign tok_out = tok_ff;

endmodule

// File: design/section_timing_profiler_table.sv
// ----------------------------------------------------------------------------
// section_timing_profiler_table
// table of timed sections held in a chain of entry cells
// ----------------------------------------------------------------------------
//  channel   dir   beat contents
//  req_bus   in    mode, section_key, timestamp
//  rsp_bus   out   status, call_count, total_time, low_time, high_time
//
//  an accepted beat enters a token into the cell chain; it moves one cell per
//  cycle and the first matching cell updates itself and fills the result
//  response register loads when the token leaves the last of the 64 cells
//  one item in flight at a time; req_bus.ready is low until the response leaves
//  synchronous reset clears the used flags and statistics of all cells at once
//  a stalled response holds in its register; the chain is empty meanwhile
// ----------------------------------------------------------------------------
module section_timing_profiler_table (
   input logic     clock,
   input logic     reset,
   stp_req_if.sink   req_bus,
   stp_rsp_if.source rsp_bus
);
   import stp_pkg::*;

   token_type tok [ENTRY_COUNT+1];

   logic        busy_ff, busy_in;
   logic        rsp_valid_ff;
   logic [1:0]  status_ff;
   logic [31:0] calls_ff;
   logic [63:0] total_ff;
   logic [47:0] low_ff, high_ff;
   logic        req_fire, rsp_fire;
   token_type   last;

   assign req_bus.ready = !busy_ff;
   assign req_fire      = req_bus.valid && req_bus.ready;
   assign rsp_fire      = rsp_bus.valid && rsp_bus.ready;

   // token injected at the head of the chain
   always_comb begin
      tok[0]            = '0;
      tok[0].valid      = req_fire;
      tok[0].mode       = req_bus.mode;
      tok[0].key        = req_bus.section_key;
      tok[0].stamp      = req_bus.timestamp;
   end

   genvar g;
   generate
      for (g = 0; g < ENTRY_COUNT; g++) begin : g_cell
         stp_cell u_cell (
            .clock   (clock),
            .reset   (reset),
            .tok_in  (tok[g]),
            .tok_out (tok[g+1])
         );
      end
   endgenerate

   assign last = tok[ENTRY_COUNT];

   // busy from accept until the response beat is taken
   always_comb begin
      busy_in = busy_ff;
      if (req_fire) busy_in = 1'b1;
      if (rsp_fire) busy_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (last.valid) begin
         if (last.done) begin
            status_ff <= last.status;
            calls_ff  <= last.call_count;
            total_ff  <= last.total_time;
            low_ff    <= last.low_time;
            high_ff   <= last.high_time;
         end else begin
            // no cell took it: full table on begin, missing key otherwise
            status_ff <= (last.mode == MODE_BEGIN) ? STATUS_FULL : STATUS_NOT_FOUND;
            calls_ff  <= '0;
            total_ff  <= '0;
            low_ff    <= '0;
            high_ff   <= '0;
         end
      end
      if (reset) begin
         busy_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         if (last.valid)    rsp_valid_ff <= 1'b1;
         else if (rsp_fire) rsp_valid_ff <= 1'b0;
      end
   end

   assign rsp_bus.valid      = rsp_valid_ff;
   assign rsp_bus.status     = status_ff;
   assign rsp_bus.call_count = calls_ff;
   assign rsp_bus.total_time = total_ff;
   assign rsp_bus.low_time   = low_ff;
   assign rsp_bus.high_time  = high_ff;

`ifndef SYNTH
   a_rsp_busy : assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> busy_ff)
      else $error("response pending while not busy");
   a_exit_busy : assert property (@(posedge clock) disable iff (reset)
      last.valid |-> (busy_ff && !rsp_valid_ff))
      else $error("token left chain with no item in flight");
   a_accept_busy : assert property (@(posedge clock) disable iff (reset)
      req_fire |=> busy_ff)
      else $error("not busy after accept");
`endif

endmodule
